// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode and json_string_unescaper_utf8; depends on nothing.
package jsu_pkg;

   // result kinds
   localparam logic [1:0] K_DATA = 2'd0;
   localparam logic [1:0] K_DONE = 2'd1;
   localparam logic [1:0] K_ERR  = 2'd2;

   // error codes
   localparam logic [2:0] E_EARLY = 3'd0;
   localparam logic [2:0] E_ESC   = 3'd1;
   localparam logic [2:0] E_HEX   = 3'd2;
   localparam logic [2:0] E_PAIR  = 3'd3;
   localparam logic [2:0] E_LOW   = 3'd4;
   localparam logic [2:0] E_LONE  = 3'd5;
   localparam logic [2:0] E_QUOTE = 3'd6;

   // surrogate ranges and supplementary plane base
   localparam logic [15:0] SURR_HI_MIN  = 16'hD800;
   localparam logic [15:0] SURR_HI_MAX  = 16'hDBFF;
   localparam logic [15:0] SURR_LO_MIN  = 16'hDC00;
   localparam logic [15:0] SURR_LO_MAX  = 16'hDFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

   // characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   typedef enum logic [6:0] {
      PH_WAIT    = 7'b0000001,
      PH_TEXT    = 7'b0000010,
      PH_ESC     = 7'b0000100,
      PH_HEX1    = 7'b0001000,
      PH_PAIR_BS = 7'b0010000,
      PH_PAIR_U  = 7'b0100000,
      PH_HEX2    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] error_code;
   } ent_type;

   // results caused by one transaction; ent[0] goes out first
   typedef struct packed {
      logic [2:0]        count;
      ent_type [3:0]     ent;
   } grp_type;

endpackage

// ===== rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
// Parser state and per-byte decode into a group of up to four results.
// Depends on jsu_pkg.
module jsu_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  jsu_pkg::req_type  req,
   output jsu_pkg::grp_type  grp
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        acc_ff, acc_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               bad_ff, bad_in;
   logic [9:0]         hs_ff, hs_in;
   logic               pbad_ff, pbad_in;

   logic [7:0]  b;
   logic        is_hex;
   logic [3:0]  hv;
   logic [15:0] acc_next;
   logic        bad_next;
   logic        four;
   logic [20:0] pair_cp;

   function automatic jsu_pkg::grp_type one_result(input logic [1:0] kind,
                                                   input logic [7:0] byte_v,
                                                   input logic [2:0] err);
      jsu_pkg::grp_type g;
      g = '0;
      g.count = 3'd1;
      g.ent[0].kind = kind;
      g.ent[0].out_byte = byte_v;
      g.ent[0].error_code = err;
      return g;
   endfunction

   function automatic jsu_pkg::grp_type utf8_group(input logic [20:0] cp);
      jsu_pkg::grp_type g;
      g = '0;
      if (cp < 21'h80) begin
         g.count = 3'd1;
         g.ent[0].out_byte = {1'b0, cp[6:0]};
      end else if (cp < 21'h800) begin
         g.count = 3'd2;
         g.ent[0].out_byte = {3'b110, cp[10:6]};
         g.ent[1].out_byte = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         g.count = 3'd3;
         g.ent[0].out_byte = {4'b1110, cp[15:12]};
         g.ent[1].out_byte = {2'b10, cp[11:6]};
         g.ent[2].out_byte = {2'b10, cp[5:0]};
      end else begin
         g.count = 3'd4;
         g.ent[0].out_byte = {5'b11110, cp[20:18]};
         g.ent[1].out_byte = {2'b10, cp[17:12]};
         g.ent[2].out_byte = {2'b10, cp[11:6]};
         g.ent[3].out_byte = {2'b10, cp[5:0]};
      end
      g.ent[0].kind = jsu_pkg::K_DATA;
      g.ent[1].kind = jsu_pkg::K_DATA;
      g.ent[2].kind = jsu_pkg::K_DATA;
      g.ent[3].kind = jsu_pkg::K_DATA;
      return g;
   endfunction

   // hex digit of the incoming byte; letters share low nibble offsets
   always_comb begin
      b = req.in_byte;
      is_hex = 1'b1;
      hv = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hv = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         hv = b[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
      acc_next = {acc_ff[11:0], hv};
      bad_next = bad_ff | ~is_hex;
      four     = (cnt_ff == 2'd3);
      pair_cp  = jsu_pkg::CP_SUPP_BASE + {1'b0, hs_ff, acc_next[9:0]};
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      bad_in   = bad_ff;
      hs_in    = hs_ff;
      pbad_in  = pbad_ff;
      grp      = '0;
      if (step) begin
         if (req.end_of_input) begin
            case (phase_ff)
               jsu_pkg::PH_TEXT, jsu_pkg::PH_ESC, jsu_pkg::PH_HEX1: begin
                  grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_EARLY);
                  phase_in = jsu_pkg::PH_WAIT;
               end
               jsu_pkg::PH_PAIR_BS, jsu_pkg::PH_PAIR_U, jsu_pkg::PH_HEX2: begin
                  grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_PAIR);
                  phase_in = jsu_pkg::PH_WAIT;
               end
               default: begin
                  phase_in = jsu_pkg::PH_WAIT;
               end
            endcase
         end else begin
            case (phase_ff)
               jsu_pkg::PH_TEXT: begin
                  if (b == jsu_pkg::CH_QUOTE) begin
                     phase_in = jsu_pkg::PH_WAIT;
                     grp = one_result(jsu_pkg::K_DONE, 8'd0, 3'd0);
                  end else if (b == jsu_pkg::CH_BSL) begin
                     phase_in = jsu_pkg::PH_ESC;
                  end else begin
                     grp = one_result(jsu_pkg::K_DATA, b, 3'd0);
                  end
               end
               jsu_pkg::PH_ESC: begin
                  phase_in = jsu_pkg::PH_TEXT;
                  case (b)
                     jsu_pkg::CH_QUOTE: grp = one_result(jsu_pkg::K_DATA, 8'h22, 3'd0);
                     jsu_pkg::CH_BSL:   grp = one_result(jsu_pkg::K_DATA, 8'h5C, 3'd0);
                     jsu_pkg::CH_SLASH: grp = one_result(jsu_pkg::K_DATA, 8'h2F, 3'd0);
                     jsu_pkg::CH_B:     grp = one_result(jsu_pkg::K_DATA, 8'h08, 3'd0);
                     jsu_pkg::CH_F:     grp = one_result(jsu_pkg::K_DATA, 8'h0C, 3'd0);
                     jsu_pkg::CH_N:     grp = one_result(jsu_pkg::K_DATA, 8'h0A, 3'd0);
                     jsu_pkg::CH_R:     grp = one_result(jsu_pkg::K_DATA, 8'h0D, 3'd0);
                     jsu_pkg::CH_T:     grp = one_result(jsu_pkg::K_DATA, 8'h09, 3'd0);
                     jsu_pkg::CH_U: begin
                        acc_in   = '0;
                        cnt_in   = '0;
                        bad_in   = 1'b0;
                        phase_in = jsu_pkg::PH_HEX1;
                     end
                     default: begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_ESC);
                        phase_in = jsu_pkg::PH_WAIT;
                     end
                  endcase
               end
               jsu_pkg::PH_HEX1: begin
                  acc_in = acc_next;
                  cnt_in = cnt_ff + 2'd1;
                  bad_in = bad_next;
                  if (four) begin
                     if (bad_next) begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_HEX);
                        phase_in = jsu_pkg::PH_WAIT;
                     end else if (acc_next >= jsu_pkg::SURR_HI_MIN &&
                                  acc_next <= jsu_pkg::SURR_HI_MAX) begin
                        hs_in    = acc_next[9:0];
                        pbad_in  = 1'b0;
                        phase_in = jsu_pkg::PH_PAIR_BS;
                     end else if (acc_next >= jsu_pkg::SURR_LO_MIN &&
                                  acc_next <= jsu_pkg::SURR_LO_MAX) begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_LONE);
                        phase_in = jsu_pkg::PH_WAIT;
                     end else begin
                        grp = utf8_group({5'd0, acc_next});
                        phase_in = jsu_pkg::PH_TEXT;
                     end
                  end
               end
               jsu_pkg::PH_PAIR_BS: begin
                  if (b != jsu_pkg::CH_BSL) begin
                     pbad_in = 1'b1;
                  end
                  phase_in = jsu_pkg::PH_PAIR_U;
               end
               jsu_pkg::PH_PAIR_U: begin
                  if (b != jsu_pkg::CH_U) begin
                     pbad_in = 1'b1;
                  end
                  acc_in   = '0;
                  cnt_in   = '0;
                  bad_in   = 1'b0;
                  phase_in = jsu_pkg::PH_HEX2;
               end
               jsu_pkg::PH_HEX2: begin
                  acc_in = acc_next;
                  cnt_in = cnt_ff + 2'd1;
                  bad_in = bad_next;
                  if (four) begin
                     if (pbad_ff) begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_PAIR);
                        phase_in = jsu_pkg::PH_WAIT;
                     end else if (bad_next) begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_HEX);
                        phase_in = jsu_pkg::PH_WAIT;
                     end else if (acc_next < jsu_pkg::SURR_LO_MIN ||
                                  acc_next > jsu_pkg::SURR_LO_MAX) begin
                        grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_LOW);
                        phase_in = jsu_pkg::PH_WAIT;
                     end else begin
                        grp = utf8_group(pair_cp);
                        phase_in = jsu_pkg::PH_TEXT;
                     end
                  end
               end
               default: begin
                  // waiting for the opening quote, or a phase code with no meaning
                  if (b == jsu_pkg::CH_QUOTE) begin
                     phase_in = jsu_pkg::PH_TEXT;
                  end else begin
                     grp = one_result(jsu_pkg::K_ERR, 8'd0, jsu_pkg::E_QUOTE);
                     phase_in = jsu_pkg::PH_WAIT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_WAIT;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         bad_ff   <= 1'b0;
         hs_ff    <= '0;
         pbad_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         bad_ff   <= bad_in;
         hs_ff    <= hs_in;
         pbad_ff  <= pbad_in;
      end
   end

endmodule

// ===== rtl/json_string_unescaper_utf8.sv =====
`timescale 1ns / 1ps
// Latency: the first result of a transaction is valid in the cycle after it is accepted.
// Throughput: one input byte per cycle while rsp_stall is low and each byte yields
// at most one result. A \u escape that encodes to more than one UTF-8 byte holds the
// single result register and stalls the input until its last byte is taken.
// Reset (synchronous): parser waits for an opening quote, result register empty.
// Top level: decoder plus result register; one result drains per cycle unless stalled.
// Depends on jsu_pkg and jsu_decode.
module json_string_unescaper_utf8 (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jsu_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jsu_pkg::rsp_type  rsp_payload
);

   jsu_pkg::grp_type      dec_grp;
   jsu_pkg::ent_type [3:0] ent_ff, ent_in;
   logic [1:0]            rem_ff, rem_in;
   logic                  grp_valid_ff, grp_valid_in;
   logic                  take;
   logic                  free;
   logic                  accept;

   assign take      = grp_valid_ff & ~rsp_stall;
   // the register frees up in the same cycle its final result leaves
   assign free      = ~grp_valid_ff | (take & (rem_ff == 2'd0));
   assign req_stall = ~free;
   assign accept    = req_valid & free;

   jsu_decode u_decode (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req_payload),
      .grp   (dec_grp)
   );

   always_comb begin
      ent_in       = ent_ff;
      rem_in       = rem_ff;
      grp_valid_in = grp_valid_ff;
      if (take) begin
         if (rem_ff == 2'd0) begin
            grp_valid_in = 1'b0;
         end else begin
            // advance to the next byte of the group
            for (int i = 0; i < 3; i++) begin
               ent_in[i] = ent_ff[i + 1];
            end
            rem_in = rem_ff - 2'd1;
         end
      end
      if (accept && dec_grp.count != 3'd0) begin
         ent_in       = dec_grp.ent;
         rem_in       = 2'(dec_grp.count - 3'd1);
         grp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign rsp_valid              = grp_valid_ff;
   assign rsp_payload.kind       = ent_ff[0].kind;
   assign rsp_payload.out_byte   = ent_ff[0].out_byte;
   assign rsp_payload.error_code = ent_ff[0].error_code;
   assign rsp_payload.last       = (rem_ff == 2'd0);

`ifndef SYNTHESIS
   a_idle_no_stall: assert property (@(posedge clock) disable iff (reset)
      !grp_valid_ff |-> !req_stall)
      else $error("input stalled with an empty result register");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (take && rem_ff != 2'd0) |=> rsp_valid)
      else $error("result group dropped before its last byte");

   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != jsu_pkg::K_DATA) |-> rsp_payload.last)
      else $error("done or error result not final in its transaction");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_grp.count != 3'd0) |-> (!grp_valid_ff || (take && rem_ff == 2'd0)))
      else $error("new group loaded over an undelivered one");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescaper_utf8: quoted strings with every escape
// form, surrogate pairs, broken input and stream ends, scored against a local decoder.
// Depends on jsu_pkg and the RTL of json_string_unescaper_utf8.
module tb;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          GEN_ITEMS   = 529;
   localparam logic [2:0]  NO_ERROR    = 3'd0;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   jsu_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   jsu_pkg::rsp_type rsp_payload;

   jsu_pkg::req_type raw_bytes[$];
   jsu_pkg::rsp_type decoded_out[$];
   jsu_pkg::rsp_type step_out[$];
   logic [7:0]       seg_buf[$];

   int   n_gen      = 0;
   int   n_accepted = 0;
   int   n_fail     = 0;
   int   cycle_count = 0;
   int   send_gap   = 0;
   int   stall_left = 0;
   int   hold_left  = 0;
   logic hold_done  = 1'b0;
   jsu_pkg::rsp_type want_rsp;

   // decoder state
   jsu_pkg::phase_type dec_phase;
   logic [15:0] dec_acc;
   logic [15:0] dec_high;
   logic [2:0]  dec_ndig;
   logic        dec_hex_bad;
   logic        dec_prefix_bad;

   json_string_unescaper_utf8 dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic logic is_hex(logic [7:0] ch);
      return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f");
   endfunction

   function automatic logic quiet_now();
      return raw_bytes.size() < 40 || (cycle_count / 128) % 4 == 3;
   endfunction

   // ---------------- decoder ----------------

   function automatic void decoder_clear();
      dec_phase      = jsu_pkg::PH_WAIT;
      dec_acc        = '0;
      dec_high       = '0;
      dec_ndig       = '0;
      dec_hex_bad    = 1'b0;
      dec_prefix_bad = 1'b0;
   endfunction

   function automatic void emit_result(logic [1:0] k, logic [7:0] ob, logic [2:0] ec);
      jsu_pkg::rsp_type r;
      r.kind       = k;
      r.out_byte   = ob;
      r.error_code = ec;
      r.last       = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void raise_error(logic [2:0] ec);
      dec_phase = jsu_pkg::PH_WAIT;
      emit_result(jsu_pkg::K_ERR, 8'h00, ec);
   endfunction

   function automatic void clear_hex();
      dec_acc     = '0;
      dec_ndig    = '0;
      dec_hex_bad = 1'b0;
   endfunction

   function automatic void shift_digit(logic [7:0] ch);
      logic [3:0] nib;
      if (ch >= "0" && ch <= "9") begin
         nib = 4'(ch - "0");
      end else if (ch >= "A" && ch <= "F") begin
         nib = 4'(ch - "A" + 8'd10);
      end else if (ch >= "a" && ch <= "f") begin
         nib = 4'(ch - "a" + 8'd10);
      end else begin
         nib         = 4'h0;
         dec_hex_bad = 1'b1;
      end
      dec_acc  = {dec_acc[11:0], nib};
      dec_ndig = dec_ndig + 3'd1;
   endfunction

   function automatic void emit_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         emit_result(jsu_pkg::K_DATA, cp[7:0], NO_ERROR);
      end else if (cp < 21'h800) begin
         emit_result(jsu_pkg::K_DATA, {3'b110, cp[10:6]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[5:0]}, NO_ERROR);
      end else if (cp < 21'h10000) begin
         emit_result(jsu_pkg::K_DATA, {4'b1110, cp[15:12]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[11:6]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[5:0]}, NO_ERROR);
      end else begin
         emit_result(jsu_pkg::K_DATA, {5'b11110, cp[20:18]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[17:12]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[11:6]}, NO_ERROR);
         emit_result(jsu_pkg::K_DATA, {2'b10, cp[5:0]}, NO_ERROR);
      end
      dec_phase = jsu_pkg::PH_TEXT;
   endfunction

   // work out the results of one accepted transaction and queue them
   function automatic void unescape_step(jsu_pkg::req_type r);
      logic [7:0]       ch;
      logic [20:0]      cp;
      jsu_pkg::rsp_type res;
      ch = r.in_byte;
      step_out.delete();
      if (r.end_of_input) begin
         if (dec_phase == jsu_pkg::PH_PAIR_BS || dec_phase == jsu_pkg::PH_PAIR_U
             || dec_phase == jsu_pkg::PH_HEX2)
            raise_error(jsu_pkg::E_PAIR);
         else if (dec_phase != jsu_pkg::PH_WAIT)
            raise_error(jsu_pkg::E_EARLY);
      end else begin
         case (dec_phase)
            jsu_pkg::PH_TEXT: begin
               if (ch == jsu_pkg::CH_QUOTE) begin
                  dec_phase = jsu_pkg::PH_WAIT;
                  emit_result(jsu_pkg::K_DONE, 8'h00, NO_ERROR);
               end else if (ch == jsu_pkg::CH_BSL) begin
                  dec_phase = jsu_pkg::PH_ESC;
               end else begin
                  emit_result(jsu_pkg::K_DATA, ch, NO_ERROR);
               end
            end
            jsu_pkg::PH_ESC: begin
               dec_phase = jsu_pkg::PH_TEXT;
               case (ch)
                  jsu_pkg::CH_QUOTE: emit_result(jsu_pkg::K_DATA, jsu_pkg::CH_QUOTE, NO_ERROR);
                  jsu_pkg::CH_BSL:   emit_result(jsu_pkg::K_DATA, jsu_pkg::CH_BSL, NO_ERROR);
                  jsu_pkg::CH_SLASH: emit_result(jsu_pkg::K_DATA, jsu_pkg::CH_SLASH, NO_ERROR);
                  jsu_pkg::CH_B:     emit_result(jsu_pkg::K_DATA, 8'h08, NO_ERROR);
                  jsu_pkg::CH_F:     emit_result(jsu_pkg::K_DATA, 8'h0C, NO_ERROR);
                  jsu_pkg::CH_N:     emit_result(jsu_pkg::K_DATA, 8'h0A, NO_ERROR);
                  jsu_pkg::CH_R:     emit_result(jsu_pkg::K_DATA, 8'h0D, NO_ERROR);
                  jsu_pkg::CH_T:     emit_result(jsu_pkg::K_DATA, 8'h09, NO_ERROR);
                  jsu_pkg::CH_U: begin
                     clear_hex();
                     dec_phase = jsu_pkg::PH_HEX1;
                  end
                  default:  raise_error(jsu_pkg::E_ESC);
               endcase
            end
            jsu_pkg::PH_HEX1: begin
               shift_digit(ch);
               if (dec_ndig == 3'd4) begin
                  if (dec_hex_bad) begin
                     raise_error(jsu_pkg::E_HEX);
                  end else if (dec_acc >= jsu_pkg::SURR_HI_MIN &&
                               dec_acc <= jsu_pkg::SURR_HI_MAX) begin
                     dec_high       = dec_acc;
                     dec_prefix_bad = 1'b0;
                     dec_phase      = jsu_pkg::PH_PAIR_BS;
                  end else if (dec_acc >= jsu_pkg::SURR_LO_MIN &&
                               dec_acc <= jsu_pkg::SURR_LO_MAX) begin
                     raise_error(jsu_pkg::E_LONE);
                  end else begin
                     emit_utf8({5'b0, dec_acc});
                  end
               end
            end
            jsu_pkg::PH_PAIR_BS: begin
               if (ch != jsu_pkg::CH_BSL)
                  dec_prefix_bad = 1'b1;
               dec_phase = jsu_pkg::PH_PAIR_U;
            end
            jsu_pkg::PH_PAIR_U: begin
               if (ch != jsu_pkg::CH_U)
                  dec_prefix_bad = 1'b1;
               clear_hex();
               dec_phase = jsu_pkg::PH_HEX2;
            end
            jsu_pkg::PH_HEX2: begin
               shift_digit(ch);
               if (dec_ndig == 3'd4) begin
                  if (dec_prefix_bad) begin
                     raise_error(jsu_pkg::E_PAIR);
                  end else if (dec_hex_bad) begin
                     raise_error(jsu_pkg::E_HEX);
                  end else if (dec_acc < jsu_pkg::SURR_LO_MIN ||
                               dec_acc > jsu_pkg::SURR_LO_MAX) begin
                     raise_error(jsu_pkg::E_LOW);
                  end else begin
                     // both halves are in range, so their low ten bits are the offsets
                     cp = ({11'b0, dec_high[9:0]} << 10) + {11'b0, dec_acc[9:0]}
                          + jsu_pkg::CP_SUPP_BASE;
                     emit_utf8(cp);
                  end
               end
            end
            default: begin
               if (ch == jsu_pkg::CH_QUOTE)
                  dec_phase = jsu_pkg::PH_TEXT;
               else
                  raise_error(jsu_pkg::E_QUOTE);
            end
         endcase
      end
      foreach (step_out[i]) begin
         res      = step_out[i];
         res.last = (i == step_out.size() - 1);
         decoded_out.insert(decoded_out.size(), res);
      end
   endfunction

   // ---------------- stimulus ----------------

   task automatic put_in(logic [7:0] ch);
      jsu_pkg::req_type r;
      r.in_byte      = ch;
      r.end_of_input = 1'b0;
      raw_bytes.insert(raw_bytes.size(), r);
      n_gen++;
   endtask

   task automatic put_end();
      jsu_pkg::req_type r;
      r.in_byte      = 8'($urandom_range(0, 255));
      r.end_of_input = 1'b1;
      raw_bytes.insert(raw_bytes.size(), r);
      n_gen++;
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++)
         put_in(s[i]);
   endtask

   task automatic flush_seg();
      foreach (seg_buf[i])
         put_in(seg_buf[i]);
      seg_buf.delete();
   endtask

   function automatic logic [7:0] rand_other(logic [7:0] avoid);
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch == avoid);
      return ch;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (is_hex(ch));
      return ch;
   endfunction

   function automatic logic [7:0] bad_escape_letter();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255));
      while (ch == jsu_pkg::CH_QUOTE || ch == jsu_pkg::CH_BSL || ch == jsu_pkg::CH_SLASH
             || ch == jsu_pkg::CH_B || ch == jsu_pkg::CH_F || ch == jsu_pkg::CH_N
             || ch == jsu_pkg::CH_R || ch == jsu_pkg::CH_T || ch == jsu_pkg::CH_U);
      return ch;
   endfunction

   function automatic logic [7:0] simple_escape();
      case ($urandom_range(0, 7))
         0:       return jsu_pkg::CH_QUOTE;
         1:       return jsu_pkg::CH_BSL;
         2:       return jsu_pkg::CH_SLASH;
         3:       return jsu_pkg::CH_B;
         4:       return jsu_pkg::CH_F;
         5:       return jsu_pkg::CH_N;
         6:       return jsu_pkg::CH_R;
         default: return jsu_pkg::CH_T;
      endcase
   endfunction

   // spread over the 1, 2 and 3 byte encodings, skipping surrogates
   function automatic logic [15:0] pick_bmp();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 16'h7F));
         1: return 16'($urandom_range(16'h80, 16'h7FF));
         2: return 16'($urandom_range(16'h800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 7))
               0:       return 16'h0000;
               1:       return 16'h007F;
               2:       return 16'h0080;
               3:       return 16'h07FF;
               4:       return 16'h0800;
               5:       return 16'hD7FF;
               6:       return 16'hE000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_high();
      case ($urandom_range(0, 5))
         0:       return jsu_pkg::SURR_HI_MIN;
         1:       return jsu_pkg::SURR_HI_MAX;
         default: return 16'($urandom_range(jsu_pkg::SURR_HI_MIN, jsu_pkg::SURR_HI_MAX));
      endcase
   endfunction

   function automatic logic [15:0] pick_low();
      case ($urandom_range(0, 5))
         0:       return jsu_pkg::SURR_LO_MIN;
         1:       return jsu_pkg::SURR_LO_MAX;
         default: return 16'($urandom_range(jsu_pkg::SURR_LO_MIN, jsu_pkg::SURR_LO_MAX));
      endcase
   endfunction

   // four digits in mixed case; a bad_pos of 0..3 spoils that digit
   task automatic seg_hex(logic [15:0] v, int bad_pos);
      logic [3:0] nib;
      logic [7:0] ch;
      for (int i = 3; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib < 10)
            ch = "0" + nib;
         else if ($urandom_range(0, 1))
            ch = 8'("a" + nib - 10);
         else
            ch = 8'("A" + nib - 10);
         if (i == bad_pos)
            ch = non_hex();
         seg_buf.insert(seg_buf.size(), ch);
      end
   endtask

   task automatic seg_esc_u();
      seg_buf.insert(seg_buf.size(), jsu_pkg::CH_BSL);
      seg_buf.insert(seg_buf.size(), jsu_pkg::CH_U);
   endtask

   // 0..3 plain byte, 4..5 simple escape, 6..7 \u in the BMP, 8..9 surrogate pair
   task automatic seg_random(int kind);
      logic [7:0] ch;
      if (kind < 4) begin
         ch = rand_other(jsu_pkg::CH_QUOTE);
         while (ch == jsu_pkg::CH_BSL)
            ch = rand_other(jsu_pkg::CH_QUOTE);
         seg_buf.insert(seg_buf.size(), ch);
      end else if (kind < 6) begin
         seg_buf.insert(seg_buf.size(), jsu_pkg::CH_BSL);
         seg_buf.insert(seg_buf.size(), simple_escape());
      end else if (kind < 8) begin
         seg_esc_u();
         seg_hex(pick_bmp(), -1);
      end else begin
         seg_esc_u();
         seg_hex(pick_high(), -1);
         seg_esc_u();
         seg_hex(pick_low(), -1);
      end
   endtask

   task automatic put_string();
      int nseg;
      nseg = $urandom_range(0, 8);
      put_in(jsu_pkg::CH_QUOTE);
      repeat (nseg) begin
         seg_random($urandom_range(0, 9));
         flush_seg();
      end
      if ($urandom_range(0, 19) == 0)
         put_end();
      else
         put_in(jsu_pkg::CH_QUOTE);
   endtask

   task automatic put_broken();
      int         fault;
      int         cut;
      logic [7:0] b1;
      logic [7:0] b2;
      fault = $urandom_range(0, 6);
      if (fault == 0) begin
         // stray bytes outside any string
         repeat ($urandom_range(1, 3))
            put_in(rand_other(jsu_pkg::CH_QUOTE));
         if ($urandom_range(0, 1))
            put_end();
      end else begin
         put_in(jsu_pkg::CH_QUOTE);
         repeat ($urandom_range(0, 2))
            seg_random(0);
         case (fault)
            1: begin
               seg_buf.insert(seg_buf.size(), jsu_pkg::CH_BSL);
               seg_buf.insert(seg_buf.size(), bad_escape_letter());
            end
            2: begin
               seg_esc_u();
               seg_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
            end
            3: begin
               seg_esc_u();
               seg_hex(pick_low(), -1);
            end
            4: begin
               seg_esc_u();
               seg_hex(pick_high(), -1);
               case ($urandom_range(0, 2))
                  0: begin
                     b1 = rand_other(jsu_pkg::CH_BSL);
                     b2 = jsu_pkg::CH_U;
                  end
                  1: begin
                     b1 = jsu_pkg::CH_BSL;
                     b2 = rand_other(jsu_pkg::CH_U);
                  end
                  default: begin
                     b1 = rand_other(jsu_pkg::CH_BSL);
                     b2 = rand_other(jsu_pkg::CH_U);
                  end
               endcase
               seg_buf.insert(seg_buf.size(), b1);
               seg_buf.insert(seg_buf.size(), b2);
               seg_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 7));
            end
            5: begin
               seg_esc_u();
               seg_hex(pick_high(), -1);
               seg_esc_u();
               if ($urandom_range(0, 1))
                  seg_hex(16'($urandom_range(0, 1) ? $urandom_range(0, 16'hDBFF)
                                                   : $urandom_range(16'hE000, 16'hFFFF)),
                          -1);
               else
                  seg_hex(pick_low(), $urandom_range(0, 3));
            end
            default: begin
               // cut an escape short and end the stream there
               seg_random($urandom_range(4, 9));
               cut = $urandom_range(0, seg_buf.size() - 1);
               while (seg_buf.size() > cut)
                  void'(seg_buf.pop_back());
            end
         endcase
         flush_seg();
         if (fault == 6)
            put_end();
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         decoder_clear();
      end else begin
         if (req_valid && !req_stall) begin
            unescape_step(req_payload);
            void'(raw_bytes.pop_front());
            n_accepted++;
         end
         // a stalled transaction must hold
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (raw_bytes.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= raw_bytes[0];
            end
         end
      end
   end

   // ---------------- receiver ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && n_accepted >= 150) begin
         // hold off long enough for the block to fill and push back on its input
         hold_done = 1'b1;
         hold_left = 399;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_now() && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_out.size() == 0) begin
            $error("unexpected result: kind %0d, out_byte %02h, error_code %0d",
                   rsp_payload.kind, rsp_payload.out_byte, rsp_payload.error_code);
            n_fail++;
         end else begin
            want_rsp = decoded_out.pop_front();
            if (rsp_payload.kind !== want_rsp.kind) begin
               $error("kind: expected %0d, got %0d", want_rsp.kind, rsp_payload.kind);
               n_fail++;
            end
            if (rsp_payload.out_byte !== want_rsp.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want_rsp.out_byte,
                      rsp_payload.out_byte);
               n_fail++;
            end
            if (rsp_payload.error_code !== want_rsp.error_code) begin
               $error("error_code: expected %0d, got %0d", want_rsp.error_code,
                      rsp_payload.error_code);
               n_fail++;
            end
            if (rsp_payload.last !== want_rsp.last) begin
               $error("last: expected %0d, got %0d", want_rsp.last, rsp_payload.last);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[json_string_unescaper_utf8] ERROR");
         $finish;
      end
   end

   initial begin
      // end of stream while waiting is dropped silently
      put_end();
      put_in(8'h00);
      // raw extremes pass through, then an unknown escape
      put_in(jsu_pkg::CH_QUOTE);
      put_in(8'h00);
      put_in(8'hFF);
      put_in(jsu_pkg::CH_BSL);
      put_in("q");
      // highest code point from a pair, then the stream ends inside the string
      put_text("\"\\uDBFF\\udfff");
      put_end();
      put_text("\"\\u0000\"");
      while (n_gen < GEN_ITEMS) begin
         if ($urandom_range(0, 3) != 0)
            put_string();
         else
            put_broken();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (raw_bytes.size() != 0 || decoded_out.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (n_fail == 0)
         $display("[json_string_unescaper_utf8] OK");
      else
         $display("[json_string_unescaper_utf8] ERROR");
      $finish;
   end

endmodule
